>>> src/mec_pkg.sv
package mec_pkg;

  // signed width of z between iterations; a value that has not yet escaped fits
  localparam int unsigned ZW = 17;
  // full product width of two z values
  localparam int unsigned PW = 2 * ZW;
  // product after the floor shift by 8
  localparam int unsigned SW = PW - 8;
  // squared magnitude and update sums
  localparam int unsigned AW = SW + 1;

  localparam int unsigned CW     = 11;  // c_real / c_imag
  localparam int unsigned LIMW   = 15;  // escape_limit
  localparam int unsigned COUNTW = 5;   // escape_count
  localparam int unsigned BANDW  = 2;   // colour_band

  localparam logic [LIMW-1:0] ESC_LIMIT_RESET = 15'd1024;

  // colour band split points on the escape count
  localparam int unsigned BAND_SPLIT0 = 3;
  localparam int unsigned BAND_SPLIT1 = 7;
  localparam int unsigned BAND_SPLIT2 = 13;
  localparam int unsigned BAND_SPLIT3 = 19;

  localparam logic [BANDW-1:0] BAND_INTERIOR = 2'd0;
  localparam logic [BANDW-1:0] BAND_OUTER    = 2'd1;
  localparam logic [BANDW-1:0] BAND_MIDDLE   = 2'd2;
  localparam logic [BANDW-1:0] BAND_INNER    = 2'd3;

  // the three registered products of one iteration
  typedef struct packed {
    logic signed [PW-1:0] rr;
    logic signed [PW-1:0] ii;
    logic signed [PW-1:0] ri;
  } prod_t;

  // one finished result from the sequencer
  typedef struct packed {
    logic              valid;
    logic [COUNTW-1:0] count;
    logic [BANDW-1:0]  band;
  } res_t;

endpackage

>>> src/mec_mul_unit.sv
module mec_mul_unit (
  input  logic                             clk_i,
  input  logic signed [mec_pkg::ZW-1:0]    zr_i,
  input  logic signed [mec_pkg::ZW-1:0]    zi_i,
  output mec_pkg::prod_t                   prod_o
);

  mec_pkg::prod_t prod_d, prod_q;

  // zr^2, zi^2 and zr*zi from the current z
  always_comb begin
    prod_d.rr = zr_i * zr_i;
    prod_d.ii = zi_i * zi_i;
    prod_d.ri = zr_i * zi_i;
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

>>> src/mec_ctrl.sv
module mec_ctrl #(
  parameter int unsigned MAX_ITER = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [mec_pkg::CW-1:0]       c_real_i,
  input  logic signed [mec_pkg::CW-1:0]       c_imag_i,
  input  logic [mec_pkg::LIMW-1:0]            escape_limit_i,
  output mec_pkg::res_t                       res_o,
  input  logic                                res_ready_i
);

  localparam int unsigned NW = $clog2(MAX_ITER + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_d, state_q;
  logic [NW-1:0] n_d, n_q;
  logic signed [mec_pkg::ZW-1:0] zr_d, zr_q, zi_d, zi_q;
  logic signed [mec_pkg::CW-1:0] cr_d, cr_q, ci_d, ci_q;

  mec_pkg::prod_t prod;

  logic signed [mec_pkg::SW-1:0] rsq, isq, tri_p;
  logic signed [mec_pkg::AW-1:0] mag, zr_sum, zi_sum;
  logic escaped, at_max;
  logic [mec_pkg::BANDW-1:0] band;

  mec_mul_unit u_mul (
    .clk_i  (clk_i),
    .zr_i   (zr_q),
    .zi_i   (zi_q),
    .prod_o (prod)
  );

  // floor shift by 8 is an arithmetic shift of the product
  assign rsq   = prod.rr[mec_pkg::PW-1:8];
  assign isq   = prod.ii[mec_pkg::PW-1:8];
  assign tri_p = prod.ri[mec_pkg::PW-1:8];

  assign mag = mec_pkg::AW'(rsq) + mec_pkg::AW'(isq);
  assign escaped = mag > $signed({{(mec_pkg::AW - mec_pkg::LIMW){1'b0}}, escape_limit_i});
  assign at_max  = n_q == NW'(MAX_ITER);

  // new z; only kept when not escaped, then it fits ZW bits
  assign zr_sum = mec_pkg::AW'(rsq) - mec_pkg::AW'(isq) + mec_pkg::AW'(cr_q);
  assign zi_sum = {tri_p, 1'b0} + mec_pkg::AW'(ci_q);

  always_comb begin
    if (at_max) begin
      band = mec_pkg::BAND_INTERIOR;
    end else if (n_q < NW'(mec_pkg::BAND_SPLIT0)) begin
      band = mec_pkg::BAND_OUTER;
    end else if (n_q < NW'(mec_pkg::BAND_SPLIT1)) begin
      band = mec_pkg::BAND_MIDDLE;
    end else if (n_q < NW'(mec_pkg::BAND_SPLIT2)) begin
      band = mec_pkg::BAND_INNER;
    end else if (n_q < NW'(mec_pkg::BAND_SPLIT3)) begin
      band = mec_pkg::BAND_MIDDLE;
    end else begin
      band = mec_pkg::BAND_OUTER;
    end
  end

  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    zr_d    = zr_q;
    zi_d    = zi_q;
    cr_d    = cr_q;
    ci_d    = ci_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cr_d    = c_real_i;
          ci_d    = c_imag_i;
          zr_d    = '0;
          zi_d    = '0;
          n_d     = '0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        state_d = S_UPD;
      end
      S_UPD: begin
        if (at_max || escaped) begin
          state_d = S_DONE;
        end else begin
          zr_d    = zr_sum[mec_pkg::ZW-1:0];
          zi_d    = zi_sum[mec_pkg::ZW-1:0];
          n_d     = n_q + NW'(1);
          state_d = S_MUL;
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q  <= n_d;
    zr_q <= zr_d;
    zi_q <= zi_d;
    cr_q <= cr_d;
    ci_q <= ci_d;
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign res_o.valid = state_q == S_DONE;
  assign res_o.count = n_q[mec_pkg::COUNTW-1:0];
  assign res_o.band  = band;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> (n_q <= NW'(MAX_ITER)))
    else $error("escape count beyond maximum");

  a_upd_after_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |-> ($past(state_q) == S_MUL))
    else $error("update without fresh products");

  a_start_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i) |=> (state_q == S_MUL && n_q == '0))
    else $error("iteration did not start from zero");

  a_interior_band: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && n_q != NW'(MAX_ITER)) |-> (res_o.band != mec_pkg::BAND_INTERIOR))
    else $error("escaped point marked interior");
`endif

endmodule

>>> src/mandelbrot_escape_counter.sv
// Mandelbrot escape-time counter. Each input word carries one point c in signed
// 3.8 fixed point (256 = 1.0); the block iterates z = z^2 + c from z = 0, with
// zr^2, zi^2 and zr*zi floor-shifted right by 8, and stops when zr^2 + zi^2 is
// strictly greater than escape_limit (reset 1024, i.e. 4.0) or after MAX_ITER
// updates. The output word gives the escape count (MAX_ITER means bounded) and a
// 2-bit colour band. One shared unit of three multipliers serves every
// iteration (products registered, then test and update), and the input is
// not ready while a point is in work. A finished word sits in an
// output register, so the next point is taken while it waits. Write
// escape_limit only while the block is idle.
module mandelbrot_escape_counter #(
  parameter int unsigned MAX_ITER = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // [10:0] c_real, [21:11] c_imag, [23:22] zero

  // output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [4:0] escape_count, [6:5] colour_band, [7] zero

  // escape limit register
  input  logic        cfg_we_i,
  input  logic [14:0] cfg_wdata_i
);

  logic [mec_pkg::LIMW-1:0] escape_limit_q;
  mec_pkg::res_t res;
  logic res_ready;

  logic out_valid_q;
  logic [mec_pkg::COUNTW-1:0] out_count_q;
  logic [mec_pkg::BANDW-1:0]  out_band_q;

  // escape limit; the user must write it only between points, the block itself does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      escape_limit_q <= mec_pkg::ESC_LIMIT_RESET;
    end else if (cfg_we_i) begin
      escape_limit_q <= cfg_wdata_i;
    end
  end

  // sequencer plus the shared multiplier unit
  mec_ctrl #(
    .MAX_ITER (MAX_ITER)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid_i),
    .in_ready_o     (s_axis_tready_o),
    .c_real_i       (s_axis_tdata_i[10:0]),
    .c_imag_i       (s_axis_tdata_i[21:11]),
    .escape_limit_i (escape_limit_q),
    .res_o          (res),
    .res_ready_i    (res_ready)
  );

  // output register: free when empty or being drained this cycle
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res.valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (res_ready && res.valid) begin
      out_count_q <= res.count;
      out_band_q  <= res.band;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_band_q, out_count_q};

endmodule

>>> tb/mandelbrot_escape_counter_tb.sv
`timescale 1ns / 1ps

module mandelbrot_escape_counter_tb;

  localparam int unsigned ITER_MAX = 24;
  localparam int unsigned CYCLE_LIMIT = 1500000;
  localparam int unsigned DRAIN_CYCLES = 2 * ITER_MAX + 12;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i;   // [10:0] c_real, [21:11] c_imag, [23:22] zero
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [7:0]  m_axis_tdata_o;   // [4:0] escape_count, [6:5] colour_band, [7] zero
  logic        cfg_we_i;
  logic [14:0] cfg_wdata_i;

  typedef struct {
    logic [mec_pkg::COUNTW-1:0] count;
    logic [mec_pkg::BANDW-1:0]  band;
  } escape_word_t;

  // predicts the escape word of each accepted point and checks the output stream
  class escape_scoreboard;
    escape_word_t              pending[$];
    logic [mec_pkg::LIMW-1:0]  limit;
    int unsigned               errors;
    int unsigned               checked;

    function new();
      limit   = mec_pkg::ESC_LIMIT_RESET;
      errors  = 0;
      checked = 0;
    endfunction

    function logic [mec_pkg::BANDW-1:0] band_for(int unsigned n);
      if (n == ITER_MAX) return mec_pkg::BAND_INTERIOR;
      if (n < mec_pkg::BAND_SPLIT0) return mec_pkg::BAND_OUTER;
      if (n < mec_pkg::BAND_SPLIT1) return mec_pkg::BAND_MIDDLE;
      if (n < mec_pkg::BAND_SPLIT2) return mec_pkg::BAND_INNER;
      if (n < mec_pkg::BAND_SPLIT3) return mec_pkg::BAND_MIDDLE;
      return mec_pkg::BAND_OUTER;
    endfunction

    function void note_point(logic signed [mec_pkg::CW-1:0] cr,
                             logic signed [mec_pkg::CW-1:0] ci);
      longint       zr, zi, rr_sq, ii_sq, ri_prod;
      int unsigned  n;
      escape_word_t w;
      zr = 0;
      zi = 0;
      n  = 0;
      while (n < ITER_MAX) begin
        // arithmetic shift of a signed value is the floor division by 256
        rr_sq = (zr * zr) >>> 8;
        ii_sq = (zi * zi) >>> 8;
        if (rr_sq + ii_sq > longint'(limit)) break;
        ri_prod = (zr * zi) >>> 8;
        zr = rr_sq - ii_sq + longint'(cr);
        zi = ri_prod + ri_prod + longint'(ci);
        n++;
      end
      w.count = n[mec_pkg::COUNTW-1:0];
      w.band  = band_for(n);
      pending.push_back(w);
    endfunction

    function void check_word(logic [7:0] data);
      escape_word_t w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected output word, expected none, actual %h", $time, data);
        errors++;
        return;
      end
      w = pending.pop_front();
      checked++;
      if (data[4:0] !== w.count) begin
        $display("%0t: escape_count mismatch, expected %0d, actual %0d",
                 $time, w.count, data[4:0]);
        errors++;
      end
      if (data[6:5] !== w.band) begin
        $display("%0t: colour_band mismatch, expected %0d, actual %0d",
                 $time, w.band, data[6:5]);
        errors++;
      end
      if (data[7] !== 1'b0) begin
        $display("%0t: pad bit mismatch, expected 0, actual %b", $time, data[7]);
        errors++;
      end
    endfunction
  endclass

  escape_scoreboard sb;

  int unsigned cycles;
  int unsigned rx_hold;
  int unsigned rx_calm;
  int unsigned tx_calm;
  int unsigned limit_writes;
  int unsigned rx_roll;

  mandelbrot_escape_counter #(
    .MAX_ITER(ITER_MAX)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // output word monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) sb.check_word(m_axis_tdata_o);
  end

  // receiver back-pressure: mostly short stalls, a few long ones, calm stretches
  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
      if (rx_calm > 0) begin
        rx_calm <= rx_calm - 1;
      end else begin
        rx_roll = $urandom_range(0, 99);
        if (rx_roll < 10) rx_hold <= $urandom_range(1, 4);
        else if (rx_roll < 12) rx_hold <= $urandom_range(20, 60);
        else if (rx_roll < 13) rx_calm <= $urandom_range(100, 400);
      end
    end
  end

  function automatic int unsigned tx_gap();
    int unsigned r;
    if (tx_calm > 0) begin
      tx_calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) tx_calm = $urandom_range(30, 100);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_point(logic signed [mec_pkg::CW-1:0] cr,
                            logic signed [mec_pkg::CW-1:0] ci);
    int unsigned gap;
    gap = tx_gap();
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= {2'b00, 22'($urandom)};
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {2'b00, ci, cr};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_point(cr, ci);
  endtask

  // hold the input until every expected word is out, then let the block settle
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_limit(logic [mec_pkg::LIMW-1:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= 15'($urandom);
    sb.limit = value;
    limit_writes++;
  endtask

  // most points near the set where counts spread, the rest anywhere, at the corners or near zero
  task automatic send_random_points(int unsigned count);
    logic signed [mec_pkg::CW-1:0] cr, ci;
    int unsigned mode;
    int          corner[5];
    corner = '{-1024, -1, 0, 1, 1023};
    for (int unsigned k = 0; k < count; k++) begin
      mode = $urandom_range(0, 9);
      if (mode < 6) begin
        cr = mec_pkg::CW'(int'($urandom_range(0, 896)) - 640);
        ci = mec_pkg::CW'(int'($urandom_range(0, 768)) - 384);
      end else if (mode < 8) begin
        cr = mec_pkg::CW'($urandom);
        ci = mec_pkg::CW'($urandom);
      end else if (mode < 9) begin
        cr = mec_pkg::CW'(corner[$urandom_range(0, 4)]);
        ci = mec_pkg::CW'(corner[$urandom_range(0, 4)]);
      end else begin
        cr = mec_pkg::CW'(int'($urandom_range(0, 16)) - 8);
        ci = mec_pkg::CW'(int'($urandom_range(0, 16)) - 8);
      end
      send_point(cr, ci);
    end
  endtask

  initial begin
    int dir_r[20];
    int dir_i[20];
    // corners, the axes, c = -2 sitting exactly on the limit, small points where
    // floor rounding of negative cross products matters, and bounded interiors
    dir_r = '{0, -1024, 1023, -1024, 1023, -1024, 1023, 0, 0, -512,
              -256, 64, 0, -1, 1, -192, 96, -300, -1, 256};
    dir_i = '{0, -1024, 1023, 1023, -1024, 0, 0, 1023, -1024, 0,
              0, 0, 256, 1, -1, 192, 160, -30, -1, 0};

    sb = new();
    cycles          = 0;
    rx_hold         = 0;
    rx_calm         = 0;
    tx_calm         = 0;
    limit_writes    = 0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset limit
    for (int k = 0; k < 20; k++) begin
      send_point(mec_pkg::CW'(dir_r[k]), mec_pkg::CW'(dir_i[k]));
    end
    send_random_points(150);
    wait_drained();
    send_random_points(150);

    // zero limit: any nonzero squared magnitude escapes, so only points whose squares floor to zero stay bounded
    write_limit(15'd0);
    send_point(11'sd0, 11'sd0);
    send_point(11'sd1, 11'sd0);
    send_point(-11'sd1, -11'sd1);
    send_point(11'sd16, 11'sd0);
    send_random_points(240);

    write_limit(15'h7fff);
    send_random_points(300);

    write_limit(15'd1);
    send_random_points(200);

    write_limit(15'($urandom_range(0, 32767)));
    send_random_points(300);

    write_limit(15'($urandom_range(0, 4095)));
    send_random_points(300);

    write_limit(mec_pkg::ESC_LIMIT_RESET);
    send_random_points(300);

    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("checked %0d escape words over %0d escape limit writes", sb.checked,
             limit_writes);
    $display("limits covered: reset, zero, full scale, one and random values");
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
src/mec_pkg.sv
src/mec_mul_unit.sv
src/mec_ctrl.sv
src/mandelbrot_escape_counter.sv
tb/mandelbrot_escape_counter_tb.sv
